// ===== design/multiply_mix_hash64_core_assert.svh =====
// Assertion macros for the multiply-mix hash core.
`ifndef MULTIPLY_MIX_HASH64_CORE_ASSERT_SVH
`define MULTIPLY_MIX_HASH64_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MMH_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MMH_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);
`else
`define MMH_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define MMH_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// ===== design/mmh64_pkg.sv =====
// Shared types and constants for the multiply-mix hash core.
package mmh64_pkg;
    localparam logic [63:0] P0 = 64'hA0761D6478BD642F;
    localparam logic [63:0] P1 = 64'hE7037ED1A0B428DB;
    localparam logic [63:0] P2 = 64'h8EBC6AF09C88C6E3;
    localparam logic [63:0] P3 = 64'h589965CC75374CC3;

    // configuration register index
    localparam logic REG_SEED = 1'b0;

    // multiplier operand select
    localparam logic [2:0] OP_LANE_A = 3'd0;
    localparam logic [2:0] OP_LANE_B = 3'd1;
    localparam logic [2:0] OP_CHUNK  = 3'd2;
    localparam logic [2:0] OP_FIN1   = 3'd3;
    localparam logic [2:0] OP_FIN2   = 3'd4;

    typedef struct packed {
        logic       take;      // latch incoming word and update window
        logic       mul_go;    // load multiplier operands and start
        logic [2:0] op;        // which mix is running
        logic       mul_done;  // write multiplier result back
        logic       out_load;  // load output register
    } mmh_cmd_t;

    typedef struct packed {
        logic need_mix;   // latched word needs a mix
        logic is_last;    // latched word ends the message
        logic [2:0] op;   // mix kind for the latched word
        logic mul_done;   // multiplier result is ready
    } mmh_stat_t;
endpackage

// ===== design/mmh64_ctrl.sv =====
// Controller state machine for the multiply-mix hash core.
`include "multiply_mix_hash64_core_assert.svh"
module mmh64_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_free,
    input  mmh64_pkg::mmh_stat_t stat,
    output mmh64_pkg::mmh_cmd_t  cmd
);
    import mmh64_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_F1   = 3'd3;
    localparam logic [2:0] S_F2   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_CHUNK;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        cmd = '0;
        cmd.op = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.need_mix)
                begin
                    cmd.mul_go = 1'b1;
                    cmd.op = stat.op;
                    op_next = stat.op;
                    state_next = S_MUL;
                end
                else if (stat.is_last)
                begin
                    cmd.mul_go = 1'b1;
                    cmd.op = OP_FIN1;
                    op_next = OP_FIN1;
                    state_next = S_F1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_done = 1'b1;
                    if (stat.is_last)
                    begin
                        state_next = S_DEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_F1:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_go = 1'b1;
                    cmd.op = OP_FIN2;
                    op_next = OP_FIN2;
                    state_next = S_F2;
                end
            end
            S_F2:
            begin
                if (stat.mul_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `MMH_ASSERT_NEXT(a_take_dec, clk, rst_n, cmd.take, (state_reg == S_DEC), "take not followed by decode")
    `MMH_ASSERT_IMPL(a_one_cmd, clk, rst_n, !(cmd.take && cmd.out_load), "take and output load together")
    `MMH_ASSERT_NEXT(a_f1_f2, clk, rst_n, (state_reg == S_F1) && stat.mul_done, (state_reg == S_F2), "final mix order broken")
endmodule

// ===== design/mmh64_dp.sv =====
// Datapath: accumulators, word window, shared multiplier and output register.
`include "multiply_mix_hash64_core_assert.svh"
module mmh64_dp #(
    parameter int LEN_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [63:0]         data_word,
    input  logic [31:0]         message_length,
    input  logic                last_word,
    input  logic [63:0]         seed,
    input  mmh64_pkg::mmh_cmd_t  cmd,
    output mmh64_pkg::mmh_stat_t stat,
    output logic                out_full,
    input  logic                out_take,
    output logic [63:0]         hash64,
    output logic [31:0]         hash32
);
    import mmh64_pkg::*;

    localparam int LW = (LEN_BITS > 32) ? 32 : LEN_BITS;
    // pair end carries one extra bit so an offset near the top does not wrap
    localparam int PW = (LEN_BITS >= 64) ? 64 : LEN_BITS + 1;

    logic [63:0] lane_a_reg, lane_b_reg, chunk_reg;
    logic [LEN_BITS-1:0] off_reg;      // offset of latched word
    logic [LEN_BITS-1:0] taken_reg;    // offset of next word
    logic [LEN_BITS-1:0] len_reg;
    logic        last_reg;
    logic [63:0] w0_reg, w1_reg, w2_reg;
    logic [63:0] mul_a_reg, mul_b_reg;
    logic [127:0] acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] h_reg;
    logic        full_reg;
    logic        pending_reg;

    logic [LEN_BITS-1:0] len_in;
    logic [LEN_BITS-1:0] blocks_end, chunk_end;
    logic [PW-1:0] pair_end;
    logic        has_chunk, big;
    logic [63:0] mixed;
    logic [63:0] mul_a, mul_b;
    logic [31:0] pa, pb;
    logic [63:0] pp;
    logic [1:0]  sh;
    logic [127:0] pp_pos;
    logic [63:0] x0, x1;
    logic [63:0] base_acc;
    logic [191:0] win;
    logic [127:0] tail;
    logic [3:0]  r;
    logic [4:0]  n;
    logic [127:0] tsh;

    always_comb
    begin
        len_in = '0;
        len_in[LW-1:0] = message_length[LW-1:0];
    end

    assign big = (len_reg > LEN_BITS'(16));
    assign blocks_end = (len_reg > LEN_BITS'(32)) ?
                        ((len_reg - LEN_BITS'(1)) & ~LEN_BITS'(31)) : '0;
    assign has_chunk = big && ((len_reg - blocks_end) > LEN_BITS'(16));
    assign chunk_end = blocks_end + (has_chunk ? LEN_BITS'(16) : LEN_BITS'(0));
    assign pair_end = PW'(off_reg) + PW'(8);

    always_comb
    begin
        stat.is_last = last_reg;
        stat.mul_done = done_reg;
        stat.need_mix = 1'b0;
        stat.op = OP_CHUNK;
        if (pending_reg && big && (off_reg[3:0] == 4'd8))
        begin
            if (pair_end <= PW'(blocks_end))
            begin
                stat.need_mix = 1'b1;
                stat.op = (off_reg[4:0] == 5'd8) ? OP_LANE_A : OP_LANE_B;
            end
            else if (has_chunk && (pair_end == PW'(chunk_end)))
            begin
                stat.need_mix = 1'b1;
                stat.op = OP_CHUNK;
            end
        end
    end

    assign mixed = acc_reg[63:0] ^ acc_reg[127:64];

    // tail window: 16 bytes ending r bytes into the newest word
    always_comb
    begin
        win = {w2_reg, w1_reg, w0_reg};
        r = (len_reg[2:0] == 3'd0) ? 4'd8 : {1'b0, len_reg[2:0]};
        tail = 128'(win >> {r, 3'b000});
        n = (len_reg > LEN_BITS'(16)) ? 5'd16 : 5'(len_reg);
        tsh = tail >> {(5'd16 - n), 3'b000};
        x0 = '0;
        x1 = '0;
        if (big)
        begin
            x0 = tail[63:0];
            x1 = tail[127:64];
        end
        else if (n == 5'd0)
        begin
        end
        else if (n < 5'd4)
        begin
            x0 = tsh[63:0];
        end
        else if (n == 5'd4)
        begin
            x0 = {48'd0, tsh[15:0]};
            x1 = {48'd0, tsh[31:16]};
        end
        else if (n <= 5'd8)
        begin
            x0 = {32'd0, tsh[31:0]};
            x1 = {32'd0, tsh[63:32]};
        end
        else
        begin
            x0 = tsh[63:0];
            x1 = tsh[127:64];
        end
    end

    // multiplier operands for each mix kind
    always_comb
    begin
        unique case (cmd.op)
            OP_LANE_A:
            begin
                mul_a = w1_reg ^ P2;
                mul_b = w2_reg ^ lane_a_reg;
            end
            OP_LANE_B:
            begin
                mul_a = w1_reg ^ P3;
                mul_b = w2_reg ^ lane_b_reg;
            end
            OP_CHUNK:
            begin
                mul_a = w1_reg ^ P1;
                mul_b = w2_reg ^ chunk_reg;
            end
            OP_FIN1:
            begin
                mul_a = x0 ^ P1;
                mul_b = x1 ^ chunk_reg;
            end
            OP_FIN2:
            begin
                mul_a = P1 ^ 64'(len_reg);
                mul_b = mixed;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one 32x32 partial product per step, four steps per 128-bit product
    always_comb
    begin
        pa = step_reg[1] ? mul_a_reg[63:32] : mul_a_reg[31:0];
        pb = step_reg[0] ? mul_b_reg[63:32] : mul_b_reg[31:0];
        pp = pa * pb;
        sh = {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
        pp_pos = {64'd0, pp} << {sh, 5'b00000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_a_reg <= '0;
            mul_b_reg <= '0;
            acc_reg <= '0;
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.mul_go)
            begin
                mul_a_reg <= mul_a;
                mul_b_reg <= mul_b;
                acc_reg <= '0;
                step_reg <= 2'd0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_reg + pp_pos;
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign base_acc = seed ^ P0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_a_reg <= '0;
            lane_b_reg <= '0;
            chunk_reg <= '0;
            taken_reg <= '0;
            off_reg <= '0;
            len_reg <= '0;
            last_reg <= 1'b0;
            w0_reg <= '0;
            w1_reg <= '0;
            w2_reg <= '0;
            full_reg <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            if (out_take)
            begin
                full_reg <= 1'b0;
            end
            if (cmd.take)
            begin
                pending_reg <= 1'b1;
                off_reg <= taken_reg;
                len_reg <= len_in;
                last_reg <= last_word;
                taken_reg <= last_word ? '0 : taken_reg + LEN_BITS'(8);
                if (taken_reg == '0)
                begin
                    lane_a_reg <= base_acc;
                    lane_b_reg <= base_acc;
                    chunk_reg <= base_acc;
                    w0_reg <= '0;
                    w1_reg <= '0;
                end
                else
                begin
                    w0_reg <= w1_reg;
                    w1_reg <= w2_reg;
                end
                w2_reg <= data_word;
            end
            if (cmd.mul_go)
            begin
                pending_reg <= 1'b0;
            end
            if (cmd.mul_done)
            begin
                unique case (cmd.op)
                    OP_LANE_A:
                    begin
                        lane_a_reg <= mixed;
                        if (pair_end == PW'(blocks_end))
                        begin
                            chunk_reg <= mixed ^ lane_b_reg;
                        end
                    end
                    OP_LANE_B:
                    begin
                        lane_b_reg <= mixed;
                        if (pair_end == PW'(blocks_end))
                        begin
                            chunk_reg <= lane_a_reg ^ mixed;
                        end
                    end
                    OP_CHUNK:
                    begin
                        chunk_reg <= mixed;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.out_load)
            begin
                full_reg <= 1'b1;
            end
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            h_reg <= mixed;
        end
    end

    assign out_full = full_reg;
    assign hash64 = h_reg;
    assign hash32 = h_reg[31:0] - h_reg[63:32];

    `MMH_ASSERT_NEXT(a_load_full, clk, rst_n, cmd.out_load, full_reg, "output load lost")
    `MMH_ASSERT_NEXT(a_last_clear, clk, rst_n, (cmd.take && last_word), (taken_reg == '0), "offset not cleared")
    `MMH_ASSERT_IMPL(a_no_overrun, clk, rst_n, !(cmd.out_load && full_reg && !out_take), "output overrun")
    `MMH_ASSERT_IMPL(a_start_idle, clk, rst_n, !(cmd.mul_go && busy_reg), "multiplier restarted while busy")
endmodule

// ===== design/multiply_mix_hash64_core.sv =====
// Top level of the multiply-mix 64-bit hash core.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in       | in_valid / in_ready    | data_word, message_length, last_word
//  out      | out_valid / out_ready  | hash64, hash32
//  cfg      | APB psel/penable/...   | hash_seed at byte address 0
//
// One word at a time. A word needing no mix is accepted, then decoded.
// A mix runs one 32x32 partial product per cycle and is then written
// back, as for a word closing a lane pair or a 16-byte chunk. The last
// word adds two final mixes and the output load; out_valid rises in the
// cycle after the output load. A finished hash holds while an unread one
// waits. Reset clears all state but the hash payload register.
module multiply_mix_hash64_core #(
    parameter int LEN_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_word,
    input  logic [31:0] message_length,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash64,
    output logic [31:0] hash32,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import mmh64_pkg::*;

    mmh_cmd_t  cmd;
    mmh_stat_t stat;
    logic [63:0] seed_reg;
    logic        out_full;
    logic        out_take;

    assign pready = 1'b1;

    // seed register, written on the APB access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == REG_SEED))
        begin
            seed_reg <= pwdata;
        end
    end

    assign prdata = (paddr == REG_SEED) ? seed_reg : 64'd0;

    assign out_valid = out_full;
    assign out_take = out_full && out_ready;

    mmh64_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (!out_full || out_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mmh64_dp #(
        .LEN_BITS (LEN_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_word      (data_word),
        .message_length (message_length),
        .last_word      (last_word),
        .seed           (seed_reg),
        .cmd            (cmd),
        .stat           (stat),
        .out_full       (out_full),
        .out_take       (out_take),
        .hash64         (hash64),
        .hash32         (hash32)
    );
endmodule
